// ----- src/ppid_pkg.sv -----
// Package for the positional PID controller: beat structs, register
// file layout, register indexes and reset values. No dependencies.
package ppid_pkg;

	localparam int unsigned SAMPLE_WIDTH       = 16;
	localparam int unsigned GAIN_FRAC_BITS_DEF = 8;
	localparam int unsigned GAIN_W             = 16;
	localparam int unsigned LIMIT_W            = 15;
	localparam int unsigned THRESH_W           = 16;
	localparam int unsigned INTEG_W            = 32;
	localparam int unsigned DRIVE_W            = 16;
	localparam int unsigned CFG_IDX_W          = 3;
	localparam int unsigned CFG_DATA_W         = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		IDX_KP_GAIN        = 3'd0,
		IDX_KI_GAIN        = 3'd1,
		IDX_KD_GAIN        = 3'd2,
		IDX_OUTPUT_LIMIT   = 3'd3,
		IDX_INTEGRAL_LIMIT = 3'd4,
		IDX_SEP_THRESHOLD  = 3'd5,
		IDX_DEADBAND       = 3'd6
	} cfg_idx_t;

	localparam logic [LIMIT_W-1:0]  OUTPUT_LIMIT_RST   = 15'd16384;
	localparam logic [LIMIT_W-1:0]  INTEGRAL_LIMIT_RST = 15'd5000;
	localparam logic [THRESH_W-1:0] SEP_THRESHOLD_RST  = 16'd20;
	localparam logic [THRESH_W-1:0] DEADBAND_RST       = 16'd1;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp_gain;
		logic signed [GAIN_W-1:0] ki_gain;
		logic signed [GAIN_W-1:0] kd_gain;
		logic [LIMIT_W-1:0]       output_limit;
		logic [LIMIT_W-1:0]       integral_limit;
		logic [THRESH_W-1:0]      separation_threshold;
		logic [THRESH_W-1:0]      deadband;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] target_value;
		logic signed [SAMPLE_WIDTH-1:0] measured_value;
	} in_beat_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive_value;
		logic                      output_clamped;
	} out_beat_t;

endpackage

// ----- src/ppid_cfg_regs.sv -----
// Configuration register file of the positional PID controller.
// Depends on ppid_pkg.
module ppid_cfg_regs import ppid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain              <= '0;
			cfg_q.ki_gain              <= '0;
			cfg_q.kd_gain              <= '0;
			cfg_q.output_limit         <= OUTPUT_LIMIT_RST;
			cfg_q.integral_limit       <= INTEGRAL_LIMIT_RST;
			cfg_q.separation_threshold <= SEP_THRESHOLD_RST;
			cfg_q.deadband             <= DEADBAND_RST;
		end else if (wr_en) begin
			case (wr_index)
				IDX_KP_GAIN:        cfg_q.kp_gain              <= wr_data[GAIN_W-1:0];
				IDX_KI_GAIN:        cfg_q.ki_gain              <= wr_data[GAIN_W-1:0];
				IDX_KD_GAIN:        cfg_q.kd_gain              <= wr_data[GAIN_W-1:0];
				IDX_OUTPUT_LIMIT:   cfg_q.output_limit         <= wr_data[LIMIT_W-1:0];
				IDX_INTEGRAL_LIMIT: cfg_q.integral_limit       <= wr_data[LIMIT_W-1:0];
				IDX_SEP_THRESHOLD:  cfg_q.separation_threshold <= wr_data[THRESH_W-1:0];
				IDX_DEADBAND:       cfg_q.deadband             <= wr_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/ppid_core.sv -----
// PID datapath: error, integral separation, deadband, P/I/D terms and clamp.
// Holds the integral sum and previous error. Depends on ppid_pkg.
module ppid_core import ppid_pkg::*; #(
	parameter int unsigned GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      advance,
	input  in_beat_t  in_beat,
	output out_beat_t out_beat
);

	localparam int unsigned EW   = SAMPLE_WIDTH + 1;
	localparam int unsigned DW   = SAMPLE_WIDTH + 2;
	localparam int unsigned PW   = GAIN_W + EW;
	localparam int unsigned DPW  = GAIN_W + DW;
	localparam int unsigned IPW  = GAIN_W + INTEG_W;
	localparam int unsigned SUMW = DPW + 2;

	logic signed [INTEG_W-1:0] integral_sum_q;
	logic signed [EW-1:0]      prev_err_q;

	logic signed [EW-1:0]      err;
	logic [EW-1:0]             err_mag;
	logic                      accumulate;
	logic signed [INTEG_W:0]   isum_wide;
	logic signed [INTEG_W-1:0] isum_sat;
	logic signed [INTEG_W-1:0] integ_use;
	logic signed [EW-1:0]      err_db;
	logic signed [DW-1:0]      diff;
	logic signed [PW-1:0]      p_prod, p_sh;
	logic signed [DPW-1:0]     d_prod, d_sh;
	logic signed [IPW-1:0]     i_prod, i_sh, ilim_pos, ilim_neg, i_clamped;
	logic signed [SUMW-1:0]    sum, olim_pos, olim_neg, drive_full;
	logic                      over_hi, over_lo;

	assign err     = EW'(in_beat.target_value) - EW'(in_beat.measured_value);
	assign err_mag = err[EW-1] ? EW'(-err) : EW'(err);

	// integral separation: accumulate raw error only when it is small
	assign accumulate = 32'(err_mag) < 32'(cfg.separation_threshold);
	assign isum_wide  = (INTEG_W+1)'(integral_sum_q) + (INTEG_W+1)'(err);

	always_comb begin
		if (isum_wide[INTEG_W] != isum_wide[INTEG_W-1])
			isum_sat = isum_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
			                               : {1'b0, {(INTEG_W-1){1'b1}}};
		else
			isum_sat = isum_wide[INTEG_W-1:0];
	end

	assign integ_use = accumulate ? isum_sat : integral_sum_q;

	assign err_db = (32'(err_mag) < 32'(cfg.deadband)) ? '0 : err;
	assign diff   = DW'(err_db) - DW'(prev_err_q);

	assign p_prod = PW'(cfg.kp_gain) * PW'(err_db);
	assign d_prod = DPW'(cfg.kd_gain) * DPW'(diff);
	assign i_prod = IPW'(cfg.ki_gain) * IPW'(integ_use);

	assign p_sh = p_prod >>> GAIN_FRAC_BITS;
	assign d_sh = d_prod >>> GAIN_FRAC_BITS;
	assign i_sh = i_prod >>> GAIN_FRAC_BITS;

	assign ilim_pos = IPW'($signed({1'b0, cfg.integral_limit}));
	assign ilim_neg = -ilim_pos;

	always_comb begin
		if (i_sh > ilim_pos)
			i_clamped = ilim_pos;
		else if (i_sh < ilim_neg)
			i_clamped = ilim_neg;
		else
			i_clamped = i_sh;
	end

	// clamped I term fits the sum width; keep it signed
	assign sum = SUMW'(p_sh) + SUMW'(i_clamped) + SUMW'(d_sh);

	assign olim_pos = SUMW'($signed({1'b0, cfg.output_limit}));
	assign olim_neg = -olim_pos;
	assign over_hi  = sum > olim_pos;
	assign over_lo  = sum < olim_neg;

	always_comb begin
		if (over_hi)
			drive_full = olim_pos;
		else if (over_lo)
			drive_full = olim_neg;
		else
			drive_full = sum;
	end

	assign out_beat.drive_value    = drive_full[DRIVE_W-1:0];
	assign out_beat.output_clamped = over_hi | over_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_sum_q <= '0;
			prev_err_q     <= '0;
		end else if (advance) begin
			integral_sum_q <= integ_use;
			prev_err_q     <= err_db;
		end
	end

endmodule

// ----- src/positional_pid_controller.sv -----
// Top level of the positional PID controller: handshakes, input and result
// registers. Depends on ppid_pkg, ppid_cfg_regs and ppid_core.
//
// Usage:
//   in channel  : in_valid / in_stall / in_data (target and measured value).
//   out channel : out_valid / out_stall / out_data (drive and clamp flag).
//   cfg channel : cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is
//                 always high, so a write lands on any cycle with cfg_valid.
//                 Registers are only to be rewritten while the block is idle.
// Path: a beat taken lands in the input register; the PID pass is
//   combinational, and the result register loads it whenever that register
//   is not held full by out_stall.
// Throughput: one beat per cycle unless out_stall blocks the result register.
//   The rate is set by the single combinational pass (error, integral update,
//   three multipliers, clamps) between the input and result registers, which
//   also closes the integral and previous error loop on each advance.
// Stall: while a result waits under out_stall, the input register still
//   holds one more beat; in_stall rises only when both are full.
// Reset: gains go to zero, limits/thresholds to their defaults, integral sum
//   and previous error to zero, and both pipeline registers empty.
module positional_pid_controller import ppid_pkg::*; #(
	parameter int unsigned GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_beat_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_beat_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg;
	in_beat_t  in_s1;
	logic      valid_s1;
	out_beat_t core_out;
	out_beat_t out_q;
	logic      out_valid_q;
	logic      out_blocked;
	logic      advance;

	assign cfg_ready = 1'b1;

	ppid_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// result register is full and the receiver holds it
	assign out_blocked = out_valid_q & out_stall;
	assign advance     = valid_s1 & ~out_blocked;
	assign in_stall    = valid_s1 & out_blocked;

	ppid_core #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.advance  (advance),
		.in_beat  (in_s1),
		.out_beat (core_out)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			in_s1 <= in_data;
		if (advance)
			out_q <= core_out;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free slot");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register not loaded after advance");

	a_drive_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.drive_value <= $signed({1'b0, cfg.output_limit}) &&
		                 out_q.drive_value >= -$signed({1'b0, cfg.output_limit})))
		else $error("drive outside output limit");

	a_clamp_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.output_clamped) |->
		(out_q.drive_value == $signed({1'b0, cfg.output_limit}) ||
		 out_q.drive_value == -$signed({1'b0, cfg.output_limit})))
		else $error("clamped drive not at limit");

endmodule
